[sv/assert_macros.svh]
// Assertion shorthands for the viscoelastic contact block.
// Needs clk_i and rst_ni in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on the rising edge, off while in reset.
`define VCF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Antecedent this cycle implies consequent in the next one.
`define VCF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/vcf_pkg.sv]
// Shared types and constants of the viscoelastic contact force block.
// No dependencies.
package vcf_pkg;

  localparam int unsigned ARMS     = 1;   // Maxwell arms in use, 1..3
  localparam int unsigned MAX_ARMS = 3;
  localparam int unsigned ARM_W    = 2;
  localparam logic [ARM_W-1:0] LAST_ARM = ARM_W'(ARMS - 1);

  localparam int unsigned V_W   = 50;     // signed multiplier operand
  localparam int unsigned MAG_W = 50;     // product magnitude after scaling
  localparam int unsigned R_W   = 51;     // signed product
  localparam int unsigned ACC_W = 53;     // force / relaxed-height accumulator

  // register map, index = paddr[4:2]
  localparam logic [2:0] REG_EQ_K       = 3'd0;
  localparam logic [2:0] REG_INV_GLASSY = 3'd1;
  localparam logic [2:0] REG_ARM0_K     = 3'd2;
  localparam logic [2:0] REG_ARM0_RLX   = 3'd3;
  localparam logic [2:0] REG_ARM1_K     = 3'd4;
  localparam logic [2:0] REG_ARM1_RLX   = 3'd5;
  localparam logic [2:0] REG_ARM2_K     = 3'd6;
  localparam logic [2:0] REG_ARM2_RLX   = 3'd7;

  typedef struct packed {
    logic [31:0]                eq_k;
    logic [31:0]                inv_glassy;
    logic [MAX_ARMS-1:0][31:0]  arm_k;
    logic [MAX_ARMS-1:0][31:0]  arm_rlx;
  } cfg_t;

  typedef struct packed {
    logic                        start;
    logic                        sh32;   // 1: scale by 2^-32, 0: by 2^-16
    logic [31:0]                 k;
    logic signed [V_W-1:0]       v;
  } mul_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic              neg;
    logic [MAG_W-1:0]  mag;
  } mul_rsp_t;

  typedef enum logic [2:0] {
    MUL_IDLE,
    MUL_LO,
    MUL_HI,
    MUL_SUM,
    MUL_DONE
  } mul_st_e;

  typedef enum logic [3:0] {
    SEQ_IDLE,
    SEQ_REL_GO,
    SEQ_REL_WT,
    SEQ_GLS_GO,
    SEQ_GLS_WT,
    SEQ_FEQ_GO,
    SEQ_FEQ_WT,
    SEQ_FARM_GO,
    SEQ_FARM_WT,
    SEQ_RLX_GO,
    SEQ_RLX_WT,
    SEQ_DONE
  } seq_st_e;

endpackage

[sv/vcf_regs.sv]
// APB configuration registers of the viscoelastic contact block.
// Depends on vcf_pkg.
module vcf_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output vcf_pkg::cfg_t cfg_o
);
  import vcf_pkg::*;

  cfg_t       cfg_q;
  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[4:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_EQ_K:       cfg_q.eq_k       <= pwdata;
        REG_INV_GLASSY: cfg_q.inv_glassy <= pwdata;
        REG_ARM0_K:     cfg_q.arm_k[0]   <= pwdata;
        REG_ARM0_RLX:   cfg_q.arm_rlx[0] <= pwdata;
        REG_ARM1_K:     cfg_q.arm_k[1]   <= pwdata;
        REG_ARM1_RLX:   cfg_q.arm_rlx[1] <= pwdata;
        REG_ARM2_K:     cfg_q.arm_k[2]   <= pwdata;
        REG_ARM2_RLX:   cfg_q.arm_rlx[2] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_EQ_K:       prdata = cfg_q.eq_k;
      REG_INV_GLASSY: prdata = cfg_q.inv_glassy;
      REG_ARM0_K:     prdata = cfg_q.arm_k[0];
      REG_ARM0_RLX:   prdata = cfg_q.arm_rlx[0];
      REG_ARM1_K:     prdata = cfg_q.arm_k[1];
      REG_ARM1_RLX:   prdata = cfg_q.arm_rlx[1];
      REG_ARM2_K:     prdata = cfg_q.arm_k[2];
      REG_ARM2_RLX:   prdata = cfg_q.arm_rlx[2];
      default:        prdata = '0;
    endcase
  end

endmodule

[sv/vcf_mul.sv]
// Shared scaled multiplier: |v| * k >> 16 or >> 32, truncated toward zero.
// One 32x32 multiplier used twice per request (low word, high word). Depends on vcf_pkg.
module vcf_mul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  vcf_pkg::mul_req_t req_i,
  output vcf_pkg::mul_rsp_t rsp_o
);
  import vcf_pkg::*;

  mul_st_e           st_q, st_d;
  logic [MAG_W-1:0]  opd_q;
  logic [31:0]       k_q;
  logic              sh32_q;
  logic              neg_q;
  logic [63:0]       lo_p_q;
  logic [49:0]       hi_p_q;
  logic [MAG_W-1:0]  mag_q;
  logic [31:0]       mul_a;
  logic [63:0]       prod;
  logic [65:0]       sum;
  logic [V_W-1:0]    v_abs;

  assign v_abs = req_i.v[V_W-1] ? V_W'(-req_i.v) : req_i.v;
  assign mul_a = (st_q == MUL_LO) ? opd_q[31:0] : {14'b0, opd_q[MAG_W-1:32]};
  assign prod  = {32'b0, mul_a} * {32'b0, k_q};
  assign sum   = sh32_q ? ({16'b0, hi_p_q} + {34'b0, lo_p_q[63:32]})
                        : ({hi_p_q, 16'b0} + {18'b0, lo_p_q[63:16]});

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      MUL_IDLE: if (req_i.start) st_d = MUL_LO;
      MUL_LO:   st_d = MUL_HI;
      MUL_HI:   st_d = MUL_SUM;
      MUL_SUM:  st_d = MUL_DONE;
      MUL_DONE: st_d = MUL_IDLE;
      default:  st_d = MUL_IDLE;
    endcase
  end

  always_comb begin
    rsp_o.busy = (st_q != MUL_IDLE);
    rsp_o.done = (st_q == MUL_DONE);
    rsp_o.neg  = neg_q;
    rsp_o.mag  = mag_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= MUL_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == MUL_IDLE && req_i.start) begin
      opd_q  <= v_abs;
      neg_q  <= req_i.v[V_W-1];
      k_q    <= req_i.k;
      sh32_q <= req_i.sh32;
    end
    if (st_q == MUL_LO) lo_p_q <= prod;
    if (st_q == MUL_HI) hi_p_q <= prod[49:0];
    if (st_q == MUL_SUM) mag_q <= sum[MAG_W-1:0];
  end

endmodule

[sv/viscoelastic_contact_force_step_top.sv]
// Top level of the viscoelastic contact force block: sequencer, state, output register.
// Depends on vcf_pkg, vcf_regs, vcf_mul and assert_macros.svh.
//
//  channel  | dir | fields (low bit up)
//  ---------+-----+-----------------------------------------------------------------
//  s_axis   | in  | tdata: tip_position[31:0]
//  m_axis   | out | tdata: contact_force[47:0], surface_position[79:48],
//           |     |        onset_position[111:80]; tuser: in_contact
//  apb      | cfg | 8 registers at 4*i, index paddr[4:2]
//
// Each request runs through one shared scaled multiplier; every product goes
// through issue, low word, high word, sum and hand back. Products per request:
// ARMS+1 when the tip is above the surface (relaxed height), ARMS+1 when in
// contact (force), ARMS (arm relaxation); plus accept and result steps. Reset
// clears the model, sequencer and output-valid state at once, not the data registers.
// A result waits in the output register; a stalled m_axis holds the sequencer
// in its final state, and s_axis_tready_o is high only when it is idle.
module viscoelastic_contact_force_step_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  input  logic [31:0]   s_axis_tdata_i,   // tip_position[31:0]
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  output logic [111:0]  m_axis_tdata_o,   // contact_force, surface_position, onset_position
  output logic          m_axis_tuser_o,   // in_contact
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import vcf_pkg::*;

  `include "assert_macros.svh"

  cfg_t     cfg;
  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  vcf_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  vcf_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  // model state
  logic signed [31:0]      surface_q;
  logic signed [31:0]      last_tip_q;
  logic signed [31:0]      onset_q;
  logic signed [31:0]      dash_q [MAX_ARMS];
  // per-request working registers
  logic signed [31:0]      tip_q;
  logic signed [31:0]      xb_q;
  logic                    contact_q;
  logic signed [ACC_W-1:0] acc_q;
  logic [ARM_W-1:0]        arm_q;
  // output register
  logic                    out_valid_q;
  logic [47:0]             out_force_q;
  logic [31:0]             out_surf_q;
  logic [31:0]             out_onset_q;
  logic                    out_contact_q;

  seq_st_e st_q, st_d;

  logic signed [31:0]      tip_in;
  logic                    accept;
  logic                    tip_above;
  logic signed [R_W-1:0]   mval;       // signed product from the shared unit
  logic signed [32:0]      arm_diff;   // xb - dashpot of the current arm
  logic                    last_arm;
  logic                    relaxed_gt;
  logic signed [ACC_W-1:0] neg_acc;
  logic [47:0]             force_sat;
  logic [31:0]             relaxed_sat;
  logic                    out_free;
  logic                    out_load;

  assign tip_in    = s_axis_tdata_i;
  assign accept    = s_axis_tvalid_i & s_axis_tready_o;
  assign tip_above = tip_in > surface_q;
  assign mval      = mul_rsp.neg ? -$signed({1'b0, mul_rsp.mag}) : $signed({1'b0, mul_rsp.mag});
  assign arm_diff  = {xb_q[31], xb_q} - {dash_q[arm_q][31], dash_q[arm_q]};
  assign last_arm  = (arm_q == LAST_ARM);
  assign relaxed_gt = mval > R_W'(tip_q);
  assign out_free  = !out_valid_q || m_axis_tready_i;

  // Relaxed height clipped to 32 bits when it becomes the surface position.
  always_comb begin
    if (mval[R_W-1:31] == '0 || mval[R_W-1:31] == '1) begin
      relaxed_sat = mval[31:0];
    end else if (mval[R_W-1]) begin
      relaxed_sat = 32'h8000_0000;
    end else begin
      relaxed_sat = 32'h7FFF_FFFF;
    end
  end

  // Force is the negated sum, clipped to 48 bits.
  assign neg_acc = -acc_q;
  always_comb begin
    if (neg_acc[ACC_W-1:47] == '0 || neg_acc[ACC_W-1:47] == '1) begin
      force_sat = neg_acc[47:0];
    end else if (neg_acc[ACC_W-1]) begin
      force_sat = 48'h8000_0000_0000;
    end else begin
      force_sat = 48'h7FFF_FFFF_FFFF;
    end
  end

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      SEQ_IDLE:    if (s_axis_tvalid_i) st_d = tip_above ? SEQ_REL_GO : SEQ_FEQ_GO;
      SEQ_REL_GO:  st_d = SEQ_REL_WT;
      SEQ_REL_WT:  if (mul_rsp.done) st_d = last_arm ? SEQ_GLS_GO : SEQ_REL_GO;
      SEQ_GLS_GO:  st_d = SEQ_GLS_WT;
      SEQ_GLS_WT:  if (mul_rsp.done) st_d = relaxed_gt ? SEQ_FEQ_GO : SEQ_RLX_GO;
      SEQ_FEQ_GO:  st_d = SEQ_FEQ_WT;
      SEQ_FEQ_WT:  if (mul_rsp.done) st_d = SEQ_FARM_GO;
      SEQ_FARM_GO: st_d = SEQ_FARM_WT;
      SEQ_FARM_WT: if (mul_rsp.done) st_d = last_arm ? SEQ_RLX_GO : SEQ_FARM_GO;
      SEQ_RLX_GO:  st_d = SEQ_RLX_WT;
      SEQ_RLX_WT:  if (mul_rsp.done) st_d = last_arm ? SEQ_DONE : SEQ_RLX_GO;
      SEQ_DONE:    if (out_free) st_d = SEQ_IDLE;
      default:     st_d = SEQ_IDLE;
    endcase
  end

  // outputs of the sequencer: handshake and multiplier operands
  always_comb begin
    s_axis_tready_o = (st_q == SEQ_IDLE);
    out_load        = (st_q == SEQ_DONE) && out_free;
    mul_req         = '0;
    unique case (st_q)
      SEQ_REL_GO: begin
        mul_req.start = 1'b1;
        mul_req.v     = V_W'(dash_q[arm_q]);
        mul_req.k     = cfg.arm_k[arm_q];
      end
      SEQ_GLS_GO: begin
        mul_req.start = 1'b1;
        mul_req.sh32  = 1'b1;
        mul_req.v     = acc_q[V_W-1:0];
        mul_req.k     = cfg.inv_glassy;
      end
      SEQ_FEQ_GO: begin
        mul_req.start = 1'b1;
        mul_req.v     = V_W'(xb_q);
        mul_req.k     = cfg.eq_k;
      end
      SEQ_FARM_GO: begin
        mul_req.start = 1'b1;
        mul_req.v     = V_W'(arm_diff);
        mul_req.k     = cfg.arm_k[arm_q];
      end
      SEQ_RLX_GO: begin
        mul_req.start = 1'b1;
        mul_req.sh32  = 1'b1;
        mul_req.v     = V_W'(arm_diff);
        mul_req.k     = cfg.arm_rlx[arm_q];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= SEQ_IDLE;
      surface_q  <= '0;
      last_tip_q <= '0;
      onset_q    <= '0;
      for (int i = 0; i < MAX_ARMS; i++) dash_q[i] <= '0;
      tip_q      <= '0;
      xb_q       <= '0;
      contact_q  <= 1'b0;
      acc_q      <= '0;
      arm_q      <= '0;
    end else begin
      st_q <= st_d;
      if (accept) begin
        tip_q      <= tip_in;
        last_tip_q <= tip_in;
        acc_q      <= '0;
        arm_q      <= '0;
        if (!tip_above) begin
          // tip at or below the surface: pinned; onset only if it was above before
          contact_q <= 1'b1;
          xb_q      <= tip_in;
          if (last_tip_q > surface_q) onset_q <= surface_q;
        end
      end
      if (mul_rsp.done) begin
        unique case (st_q)
          SEQ_REL_WT, SEQ_FARM_WT: begin
            acc_q <= acc_q + ACC_W'(mval);
            arm_q <= last_arm ? '0 : arm_q + 1'b1;
          end
          SEQ_FEQ_WT: acc_q <= acc_q + ACC_W'(mval);
          SEQ_GLS_WT: begin
            acc_q <= '0;
            if (relaxed_gt) begin
              contact_q <= 1'b1;     // relaxed surface would pass the tip
              xb_q      <= tip_q;
            end else begin
              contact_q <= 1'b0;     // free relaxation
              xb_q      <= relaxed_sat;
            end
          end
          SEQ_RLX_WT: begin
            dash_q[arm_q] <= dash_q[arm_q] + mval[31:0];
            arm_q         <= last_arm ? '0 : arm_q + 1'b1;
          end
          default: ;
        endcase
      end
      if (out_load) surface_q <= xb_q;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_force_q   <= contact_q ? force_sat : '0;
      out_surf_q    <= xb_q;
      out_onset_q   <= onset_q;
      out_contact_q <= contact_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_onset_q, out_surf_q, out_force_q};
  assign m_axis_tuser_o  = out_contact_q;

  // checks
  `VCF_ASSERT(a_idle_unit_free, s_axis_tready_o |-> !mul_rsp.busy,
              "input taken while the multiplier is still working")
  `VCF_ASSERT_NEXT(a_busy_after_accept, accept, !s_axis_tready_o,
                   "ready stayed high after a request was accepted")
  `VCF_ASSERT(a_done_when_waiting, mul_rsp.done |-> (st_q == SEQ_REL_WT ||
              st_q == SEQ_GLS_WT || st_q == SEQ_FEQ_WT || st_q == SEQ_FARM_WT ||
              st_q == SEQ_RLX_WT), "product returned with nobody waiting")
  `VCF_ASSERT(a_arm_in_range, arm_q <= LAST_ARM, "arm index beyond the arms in use")

endmodule
